[design/tgbc_pkg.sv]
// ----------------------------------------------------------------------------
// Tile grid box collision package
// Shared types, constants and request codes for the tile grid collision block.
// ----------------------------------------------------------------------------
`default_nettype none

package tgbc_pkg;

   localparam int GRID_COLS_MAX_DEF = 128;
   localparam int GRID_ROWS_MAX_DEF = 128;
   localparam int KIND_COUNT_DEF    = 256;

   // Request codes.
   localparam logic [2:0] REQ_WRITE_TILE  = 3'd0;
   localparam logic [2:0] REQ_WRITE_SOLID = 3'd1;
   localparam logic [2:0] REQ_READ_TILE   = 3'd2;
   localparam logic [2:0] REQ_OVERLAP     = 3'd3;
   localparam logic [2:0] REQ_RESOLVE     = 3'd4;

   // Register indexes.
   localparam logic [1:0] CSR_MAP_COLS    = 2'd0;
   localparam logic [1:0] CSR_MAP_ROWS    = 2'd1;
   localparam logic [1:0] CSR_TILE_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_TILE_HEIGHT = 2'd3;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [6:0]         cell_col;
      logic [6:0]         cell_row;
      logic [7:0]         tile_kind;
      logic               solid_flag;
      logic signed [19:0] box_x;
      logic signed [19:0] box_y;
      logic [9:0]         box_w;
      logic [9:0]         box_h;
      logic               box_active;
   } req_type_type;

   typedef struct packed {
      logic [7:0]         read_kind;
      logic               read_solid;
      logic               overlap_hit;
      logic signed [19:0] out_x;
      logic signed [19:0] out_y;
      logic               stop_vx;
      logic               stop_vy;
   } rsp_type_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVX0,
      ST_DIVX1,
      ST_DIVY0,
      ST_DIVY1,
      ST_SETUP,
      ST_RDREQ,
      ST_RDWAIT,
      ST_RDUSE,
      ST_CELL,
      ST_CLAMP,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic load;
      logic div_start;
      logic div_sel_y;
      logic div_sel_end;
      logic setup;
      logic rd_issue;
      logic cell_eval;
      logic next_cell;
      logic clamp;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic div_done;
      logic scan_empty;
      logic scan_last;
      logic hit;
      logic simple_req;
      logic is_resolve;
      logic is_overlap;
      logic inactive;
      logic zero_size;
   } sts_type;

endpackage

`default_nettype wire

[design/tgbc_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tgbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[design/tgbc_div.sv]
// ----------------------------------------------------------------------------
// Floor divider
// Restoring divider for a signed dividend and a positive divisor, one
// quotient bit per cycle, giving the floor quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module tgbc_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [21:0] dividend,
   input  wire logic        [11:0] divisor,
   output logic                    done,
   output logic signed      [21:0] quotient
);

   localparam int NB = 22;

   logic [NB-1:0] rem_ff, rem_in;
   logic [NB-1:0] quo_ff, quo_in;
   logic [NB-1:0] mag_ff, mag_in;
   logic [11:0]   dvs_ff, dvs_in;
   logic          neg_ff, neg_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [NB-1:0] trial;
   logic [NB-1:0] q_adj;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      mag_in  = mag_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[NB-2:0], mag_ff[NB-1]};
      if (start) begin
         neg_in = dividend[NB-1];
         // For a negative dividend, floor(a/b) = -ceil(-a/b) = -((-a-1)/b) - 1.
         mag_in = dividend[NB-1] ? ~dividend : dividend;
         dvs_in = divisor;
         rem_in = '0;
         quo_in = '0;
         cnt_in = 5'(NB);
         run_in = 1'b1;
      end else if (run_ff) begin
         mag_in = {mag_ff[NB-2:0], 1'b0};
         if (trial >= NB'(dvs_ff)) begin
            rem_in = trial - NB'(dvs_ff);
            quo_in = {quo_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      mag_ff <= mag_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign q_adj    = neg_ff ? ~quo_ff : quo_ff;
   assign quotient = signed'(q_adj);
   assign done     = done_ff;

endmodule

`default_nettype wire

[design/tgbc_datapath.sv]
// ----------------------------------------------------------------------------
// Tile grid datapath
// Tile memory, solid table, configuration, coverage divider, cell scan and
// push-out arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module tgbc_datapath #(
   parameter int GRID_COLS_MAX = 128,
   parameter int GRID_ROWS_MAX = 128,
   parameter int KIND_COUNT    = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tgbc_pkg::req_type_type req_data,
   input  wire logic                  csr_valid,
   input  wire logic [1:0]            csr_index,
   input  wire logic [7:0]            csr_data,
   input  wire tgbc_pkg::cmd_type     cmd,
   output tgbc_pkg::sts_type          sts,
   output tgbc_pkg::rsp_type_type     rsp_data
);
   import tgbc_pkg::*;

   localparam int CW    = $clog2(GRID_COLS_MAX) > 0 ? $clog2(GRID_COLS_MAX) : 1;
   localparam int RW    = $clog2(GRID_ROWS_MAX) > 0 ? $clog2(GRID_ROWS_MAX) : 1;
   localparam int DEPTH = GRID_COLS_MAX * GRID_ROWS_MAX;
   localparam int AW    = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
   localparam int KW    = $clog2(KIND_COUNT);
   localparam int CLR_N = DEPTH > KIND_COUNT ? DEPTH : KIND_COUNT;
   localparam int CLRW  = $clog2(CLR_N + 1);

   // Configuration.
   logic [7:0] cols_ff, rows_ff, tw_ff, th_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= 8'd128;
         rows_ff <= 8'd128;
         tw_ff   <= 8'd16;
         th_ff   <= 8'd16;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAP_COLS:    cols_ff <= csr_data;
            CSR_MAP_ROWS:    rows_ff <= csr_data;
            CSR_TILE_WIDTH:  tw_ff   <= csr_data;
            CSR_TILE_HEIGHT: th_ff   <= csr_data;
            default:         cols_ff <= cols_ff;
         endcase
      end
   end

   // Effective grid size and tile size in Q4.
   logic [10:0] ecols, erows;
   logic [11:0] twq, thq;
   always_comb begin
      ecols = (cols_ff == 8'd0) ? 11'd1 : 11'(cols_ff);
      if (ecols > 11'(GRID_COLS_MAX)) ecols = 11'(GRID_COLS_MAX);
      erows = (rows_ff == 8'd0) ? 11'd1 : 11'(rows_ff);
      if (erows > 11'(GRID_ROWS_MAX)) erows = 11'(GRID_ROWS_MAX);
      twq = {(tw_ff == 8'd0) ? 8'd1 : tw_ff, 4'd0};
      thq = {(th_ff == 8'd0) ? 8'd1 : th_ff, 4'd0};
   end

   // Latched request.
   req_type_type rq_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) rq_ff <= req_data;
   end

   // Clearing pass counter; it covers both the tile memory and the solid table.
   logic [CLRW-1:0] clr_ff;
   logic            clearing;
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
   end
   assign clearing = clr_ff != CLRW'(CLR_N);

   // Scan state.
   logic signed [21:0] x_ff, y_ff, x_in, y_in;
   logic signed [21:0] c0_ff, c1_ff, r0_ff, r1_ff;
   logic [10:0] c_ff, r_ff, c0u, c1u, r0u, r1u;
   logic [21:0] tx_ff, ty_ff;
   logic svx_ff, svy_ff, svx_in, svy_in;
   logic solid_ff_c;
   logic [7:0] rd_kind;

   // Tile memory access. For requests other than overlap and resolve the read port stays on the request cell.
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data;
   logic          req_in_grid;
   logic          scan_req;
   always_comb begin
      req_in_grid = (11'(req_data.cell_col) < ecols) && (11'(req_data.cell_row) < erows);
      scan_req    = rq_ff.req_type == REQ_OVERLAP || rq_ff.req_type == REQ_RESOLVE;
      if (clearing) begin
         wr_en   = clr_ff < CLRW'(DEPTH);
         wr_addr = AW'(clr_ff);
         wr_data = 8'd0;
      end else begin
         wr_en   = cmd.load && req_data.req_type == REQ_WRITE_TILE && req_in_grid;
         wr_addr = AW'(32'(req_data.cell_row) * GRID_COLS_MAX + 32'(req_data.cell_col));
         wr_data = req_data.tile_kind;
      end
      if (cmd.load)
         rd_addr = AW'(32'(req_data.cell_row) * GRID_COLS_MAX + 32'(req_data.cell_col));
      else if (scan_req)
         rd_addr = AW'(32'(r_ff) * GRID_COLS_MAX + 32'(c_ff));
      else
         rd_addr = AW'(32'(rq_ff.cell_row) * GRID_COLS_MAX + 32'(rq_ff.cell_col));
   end

   tgbc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_kind)
   );

   // Solid table memory, loaded by the clearing pass and read at the kind just read.
   logic          sl_wr_en;
   logic [KW-1:0] sl_wr_addr;
   logic [0:0]    sl_wr_data;
   logic [0:0]    solid_rd;
   logic          kind_ok;
   always_comb begin
      if (clearing) begin
         sl_wr_en   = clr_ff < CLRW'(KIND_COUNT);
         sl_wr_addr = KW'(clr_ff);
         sl_wr_data = clr_ff != '0;
      end else begin
         sl_wr_en   = cmd.load && req_data.req_type == REQ_WRITE_SOLID &&
                      {1'b0, req_data.tile_kind} < 9'(KIND_COUNT);
         sl_wr_addr = KW'(req_data.tile_kind);
         sl_wr_data = req_data.solid_flag;
      end
      kind_ok = {1'b0, rd_kind} < 9'(KIND_COUNT);
   end

   tgbc_ram #(.WIDTH(1), .DEPTH(KIND_COUNT)) u_solid (
      .clock  (clock),
      .wr_en  (sl_wr_en),
      .wr_addr(sl_wr_addr),
      .wr_data(sl_wr_data),
      .rd_addr(KW'(rd_kind)),
      .rd_data(solid_rd)
   );

   // Coverage divider, shared by the four bounds.
   logic               div_done;
   logic signed [21:0] div_q, div_a;
   logic [11:0]        div_b;
   logic signed [21:0] x2, y2;
   assign x2 = 22'(rq_ff.box_x) + 22'({rq_ff.box_w, 4'd0});
   assign y2 = 22'(rq_ff.box_y) + 22'({rq_ff.box_h, 4'd0});
   always_comb begin
      case ({cmd.div_sel_y, cmd.div_sel_end})
         2'b00:   div_a = 22'(rq_ff.box_x);
         2'b01:   div_a = x2 - 22'sd16;
         2'b10:   div_a = 22'(rq_ff.box_y);
         default: div_a = y2 - 22'sd16;
      endcase
      div_b = cmd.div_sel_y ? thq : twq;
   end

   tgbc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(div_a),
      .divisor (div_b),
      .done    (div_done),
      .quotient(div_q)
   );

   // Capture bounds as the divider finishes, the select held by the controller.
   always_ff @(posedge clock) begin
      if (div_done) begin
         case ({cmd.div_sel_y, cmd.div_sel_end})
            2'b00:   c0_ff <= div_q;
            2'b01:   c1_ff <= div_q;
            2'b10:   r0_ff <= div_q;
            default: r1_ff <= div_q;
         endcase
      end
   end

   // Clipped bounds; a negative end bound means nothing is covered.
   always_comb begin
      c0u = c0_ff < 0 ? 11'd0 : (c0_ff > 22'sd1023 ? 11'd1023 : 11'(c0_ff));
      r0u = r0_ff < 0 ? 11'd0 : (r0_ff > 22'sd1023 ? 11'd1023 : 11'(r0_ff));
      c1u = c1_ff >= signed'(22'(ecols)) ? ecols - 11'd1 : 11'(c1_ff);
      r1u = r1_ff >= signed'(22'(erows)) ? erows - 11'd1 : 11'(r1_ff);
   end

   // Axis penetration against the current tile.
   logic signed [21:0] cx2, cy2, tx2, ty2, px, py, ax, ay;
   logic signed [21:0] wq, hq;
   always_comb begin
      wq  = 22'({rq_ff.box_w, 4'd0});
      hq  = 22'({rq_ff.box_h, 4'd0});
      cx2 = x_ff + wq;
      cy2 = y_ff + hq;
      tx2 = signed'(tx_ff) + 22'(twq);
      ty2 = signed'(ty_ff) + 22'(thq);
      px  = '0;
      py  = '0;
      if (cx2 > signed'(tx_ff) && x_ff < tx2)
         px = (cx2 - signed'(tx_ff)) < (tx2 - x_ff) ? signed'(tx_ff) - cx2 : tx2 - x_ff;
      if (cy2 > signed'(ty_ff) && y_ff < ty2)
         py = (cy2 - signed'(ty_ff)) < (ty2 - y_ff) ? signed'(ty_ff) - cy2 : ty2 - y_ff;
      ax = px < 0 ? -px : px;
      ay = py < 0 ? -py : py;
   end

   // Map extent in Q4 and clamp.
   logic signed [21:0] cxm, cym;
   logic cvx, cvy;
   logic signed [21:0] mw_ff, mh_ff;
   always_comb begin
      cxm = x_ff;
      cym = y_ff;
      cvx = svx_ff;
      cvy = svy_ff;
      if (cxm < 0) begin cxm = '0; cvx = 1'b1; end
      if (cym < 0) begin cym = '0; cvy = 1'b1; end
      if (cxm + wq > mw_ff) begin cxm = mw_ff - wq; cvx = 1'b1; end
      if (cym + hq > mh_ff) begin cym = mh_ff - hq; cvy = 1'b1; end
   end

   // Position and flag updates.
   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      svx_in = svx_ff;
      svy_in = svy_ff;
      if (cmd.setup) begin
         x_in   = 22'(rq_ff.box_x);
         y_in   = 22'(rq_ff.box_y);
         svx_in = 1'b0;
         svy_in = 1'b0;
      end else if (cmd.cell_eval && solid_ff_c && px != 0 && py != 0) begin
         if (ax < ay) begin
            x_in   = x_ff + px;
            svx_in = 1'b1;
         end else begin
            y_in   = y_ff + py;
            svy_in = 1'b1;
         end
      end else if (cmd.clamp) begin
         x_in   = cxm;
         y_in   = cym;
         svx_in = cvx;
         svy_in = cvy;
      end
   end

   // Solid flag of the tile just read.
   always_ff @(posedge clock) begin
      if (cmd.rd_issue) solid_ff_c <= 1'b0;
      else solid_ff_c <= solid_rd[0] && kind_ok;
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      svx_ff <= svx_in;
      svy_ff <= svy_in;
      // Map extents are registered from the configuration; multipliers stay small.
      mw_ff  <= 22'(ecols) * 22'(twq);
      mh_ff  <= 22'(erows) * 22'(thq);
      if (cmd.setup) begin
         c_ff  <= c0u;
         r_ff  <= r0u;
         tx_ff <= 22'(c0u) * 22'(twq);
         ty_ff <= 22'(r0u) * 22'(thq);
      end else if (cmd.next_cell) begin
         if (c_ff >= c1u) begin
            c_ff  <= c0u;
            r_ff  <= r_ff + 11'd1;
            tx_ff <= 22'(c0u) * 22'(twq);
            ty_ff <= ty_ff + 22'(thq);
         end else begin
            c_ff  <= c_ff + 11'd1;
            tx_ff <= tx_ff + 22'(twq);
         end
      end
   end

   // Overlap hit accumulation.
   logic hit_ff;
   always_ff @(posedge clock) begin
      if (cmd.setup) hit_ff <= 1'b0;
      else if (cmd.cell_eval && solid_ff_c) hit_ff <= 1'b1;
   end

   // Result assembly.
   logic rd_valid;
   assign rd_valid = (11'(rq_ff.cell_col) < ecols) && (11'(rq_ff.cell_row) < erows);
   logic signed [21:0] sx, sy;
   always_comb begin
      sx = x_ff > 22'sd524287 ? 22'sd524287 : (x_ff < -22'sd524288 ? -22'sd524288 : x_ff);
      sy = y_ff > 22'sd524287 ? 22'sd524287 : (y_ff < -22'sd524288 ? -22'sd524288 : y_ff);
      rsp_data = '0;
      case (rq_ff.req_type)
         REQ_READ_TILE: begin
            if (rd_valid) begin
               rsp_data.read_kind  = rd_kind;
               rsp_data.read_solid = solid_rd[0] && kind_ok;
            end
         end
         REQ_OVERLAP: rsp_data.overlap_hit = hit_ff;
         REQ_RESOLVE: begin
            if (!rq_ff.box_active) begin
               rsp_data.out_x = rq_ff.box_x;
               rsp_data.out_y = rq_ff.box_y;
            end else begin
               rsp_data.out_x   = 20'(sx);
               rsp_data.out_y   = 20'(sy);
               rsp_data.stop_vx = svx_ff;
               rsp_data.stop_vy = svy_ff;
            end
         end
         default: rsp_data = '0;
      endcase
   end

   // Status.
   always_comb begin
      sts.clear_last = clr_ff == CLRW'(CLR_N - 1);
      sts.div_done   = div_done;
      sts.scan_empty = (c0u > c1u) || (r0u > r1u) || c1_ff < 0 || r1_ff < 0;
      sts.scan_last  = (c_ff >= c1u) && (r_ff >= r1u);
      sts.hit        = hit_ff;
      sts.simple_req = rq_ff.req_type != REQ_OVERLAP && rq_ff.req_type != REQ_RESOLVE;
      sts.is_resolve = rq_ff.req_type == REQ_RESOLVE;
      sts.is_overlap = rq_ff.req_type == REQ_OVERLAP;
      sts.inactive   = !rq_ff.box_active;
      sts.zero_size  = rq_ff.box_w == 10'd0 || rq_ff.box_h == 10'd0;
   end

endmodule

`default_nettype wire

[design/tgbc_ctrl.sv]
// ----------------------------------------------------------------------------
// Tile grid controller
// Sequences clearing, coverage division, the cell scan and the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module tgbc_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire tgbc_pkg::sts_type sts,
   output tgbc_pkg::cmd_type      cmd,
   output logic                   busy,
   output logic                   rsp_valid
);
   import tgbc_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] dsel_ff, dsel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         dsel_ff  <= '0;
      end else begin
         state_ff <= state_in;
         dsel_ff  <= dsel_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      dsel_in         = dsel_ff;
      cmd             = '0;
      cmd.div_sel_y   = dsel_ff[1];
      cmd.div_sel_end = dsel_ff[0];
      busy            = 1'b1;
      rsp_valid       = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
            if (start) state_in = ST_DIVX0;
         end
         ST_DIVX0: begin
            // Simple requests and inactive resolves skip the division and the scan.
            if (sts.simple_req || (sts.is_resolve && sts.inactive)) begin
               state_in = ST_DONE;
            end else begin
               dsel_in       = 2'b00;
               state_in      = ST_DIVX1;
            end
         end
         ST_DIVX1: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVY0;
         end
         ST_DIVY0: begin
            if (sts.div_done) begin
               if (dsel_ff == 2'b11) begin
                  state_in = ST_SETUP;
               end else begin
                  dsel_in  = dsel_ff + 2'd1;
                  state_in = ST_DIVX1;
               end
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_DIVY1;
         end
         ST_DIVY1: begin
            if (sts.scan_empty || (sts.is_overlap && sts.zero_size))
               state_in = sts.is_resolve ? ST_CLAMP : ST_DONE;
            else
               state_in = ST_RDREQ;
         end
         ST_RDREQ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_RDWAIT;
         end
         ST_RDWAIT: state_in = ST_RDUSE;
         ST_RDUSE: state_in = ST_CELL;
         ST_CELL: begin
            cmd.cell_eval = 1'b1;
            if (sts.scan_last) begin
               state_in = sts.is_resolve ? ST_CLAMP : ST_DONE;
            end else begin
               cmd.next_cell = 1'b1;
               state_in      = ST_RDREQ;
            end
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            rsp_valid  = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // A result strobe only ever closes an item.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result strobe while idle");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff != ST_IDLE) else $error("item taken but controller idle");
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

[design/tile_grid_box_collision.sv]
// Tile writes, flag writes, reads and inactive resolves skip the division and the scan.
// Overlap and resolve run the four coverage divisions in turn (each a start, 22
// quotient bits and a done), then read and test each covered tile in turn through
// the single read port of the tile memory (states RDREQ, RDWAIT, RDUSE, CELL).
// One item at a time; results strobe for one cycle and cannot be stalled.
// After reset a clearing pass zeroes the tiles and loads the solid table.
`default_nettype none

module tile_grid_box_collision #(
   parameter int GRID_COLS_MAX = tgbc_pkg::GRID_COLS_MAX_DEF,
   parameter int GRID_ROWS_MAX = tgbc_pkg::GRID_ROWS_MAX_DEF,
   parameter int KIND_COUNT    = tgbc_pkg::KIND_COUNT_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire tgbc_pkg::req_type_type req_data,
   output logic                        rsp_valid,
   output tgbc_pkg::rsp_type_type      rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [1:0]             csr_index,
   input  wire logic [7:0]             csr_data
);
   import tgbc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   tgbc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy),
      .rsp_valid(rsp_valid)
   );

   tgbc_datapath #(
      .GRID_COLS_MAX(GRID_COLS_MAX),
      .GRID_ROWS_MAX(GRID_ROWS_MAX),
      .KIND_COUNT   (KIND_COUNT)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
